// ===== design/nc5_pkg.sv =====
// shared types, constants and helpers for the normalized 5x5 convolution
package nc5_pkg;

  localparam int KTAPS  = 25;
  localparam int KSIDE  = 5;
  localparam int NSLOTS = 5;

  localparam logic KIND_COEFF = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef struct packed {
    logic               kind;
    logic        [4:0]  coeff_index;
    logic signed [15:0] coeff_value;
    logic        [15:0] pixel_red;
    logic        [15:0] pixel_green;
    logic        [15:0] pixel_blue;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  out_row;
    logic [8:0]  out_col;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic        zero_weight;
    logic        last_of_run;
    logic        frame_end;
  } out_item_t;

  // remainder by five of a small value (below fifteen)
  function automatic logic [2:0] mod5(input logic [3:0] v);
    logic [3:0] r;
    if (v >= 4'd10) begin
      r = v - 4'd10;
    end else if (v >= 4'd5) begin
      r = v - 4'd5;
    end else begin
      r = v;
    end
    return r[2:0];
  endfunction

endpackage

// ===== design/normalized_5x5_convolution.sv =====
// normalized 5x5 convolution over a streamed square rgb image
// sequence: results of a pixel start the cycle after its transfer; each result reads
//   the 25 taps, drains the pipeline, sets up the dividers, divides and hands over
// input flow: after a pixel causing results, input is held off until the last is out,
//   at a pace set by the single line store read port, the dividers and output stalls
// reset: kernel cleared to zero, image size 512, frame position row 0 column 0;
//   the line store is not cleared and holds nothing meaningful until written
module normalized_5x5_convolution #(
  parameter int MAX_SIZE = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [9:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  nc5_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output nc5_pkg::out_item_t  out_item_o
);
  import nc5_pkg::*;

  localparam int NW    = $clog2(MAX_SIZE + 1);
  localparam int SW    = NW + 2;
  localparam int DEPTH = NSLOTS * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TAPS  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_PREP  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state_q;

  // configuration and frame position
  logic [9:0]    image_size_q;
  logic [NW-1:0] n_eff;
  logic [NW-1:0] in_row_q, in_col_q;
  logic [2:0]    in_slot_q;

  // kernel
  logic signed [15:0] coeff_q [KTAPS];

  // line store: five row slots of MAX_SIZE pixels, read data registered
  logic [47:0]   row_mem [DEPTH];
  logic [47:0]   rd_data_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  // output run bounds and walk
  logic [NW-1:0] r_q, c_q, r_hi_q, c_lo_q, c_hi_q;
  logic [2:0]    r_slot_q;

  // tap sequencer
  logic [4:0] t_q;
  logic [2:0] dr_q, dc_q;
  logic       drain_q;

  // accumulation pipeline
  logic                      v1_q, v2_q;
  logic signed [15:0]        w1_q, w2_q;
  logic signed [2:0][32:0]   prod_q;
  logic signed [2:0][37:0]   acc_q;
  logic signed [21:0]        wsum_q;

  // dividers, one per component
  logic [2:0][36:0] rem_q;
  logic [2:0][15:0] quo_q;
  logic [2:0]       neg_q, ovf_q;
  logic [36:0]      dsh_q;
  logic [3:0]       div_cnt_q;
  logic             zero_q;

  // output register
  logic      out_valid_q;
  out_item_t out_item_q;

  logic in_fire, cfg_fire, out_fire, out_free;

  // a pending register write goes first
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // size clamped to 1..MAX_SIZE
  always_comb begin
    if (image_size_q == 10'd0) begin
      n_eff = NW'(1);
    end else if (32'(image_size_q) > MAX_SIZE) begin
      n_eff = NW'(MAX_SIZE);
    end else begin
      n_eff = NW'(image_size_q);
    end
  end

  // position of the incoming pixel, back to the origin when out of frame
  logic          pos_wrap;
  logic [NW-1:0] px_row, px_col;
  logic [2:0]    px_slot;
  logic          row_last, col_last, has_rows, has_cols;

  always_comb begin
    pos_wrap = (in_row_q >= n_eff) || (in_col_q >= n_eff);
    px_row   = pos_wrap ? '0 : in_row_q;
    px_col   = pos_wrap ? '0 : in_col_q;
    px_slot  = pos_wrap ? 3'd0 : in_slot_q;
    row_last = (px_row == n_eff - NW'(1));
    col_last = (px_col == n_eff - NW'(1));
    has_rows = row_last || (px_row >= NW'(2));
    has_cols = col_last || (px_col >= NW'(2));
  end

  assign wr_en   = in_fire && (in_item_i.kind == KIND_PIXEL);
  assign wr_addr = AW'(px_slot) * AW'(MAX_SIZE) + AW'(px_col);

  // neighbour of the current output for the tap being issued
  logic signed [SW-1:0] nb_row, nb_col;
  logic                 nb_in;
  logic [2:0]           nb_slot;

  always_comb begin
    nb_row  = signed'({2'b00, r_q}) + signed'(SW'(dr_q)) - signed'(SW'(2));
    nb_col  = signed'({2'b00, c_q}) + signed'(SW'(dc_q)) - signed'(SW'(2));
    nb_in   = !nb_row[SW-1] && !nb_col[SW-1]
              && (nb_row < signed'({2'b00, n_eff}))
              && (nb_col < signed'({2'b00, n_eff}));
    // -2 is +3 modulo five
    nb_slot = mod5(4'(r_slot_q) + 4'(dr_q) + 4'd3);
    rd_addr = AW'(nb_slot) * AW'(MAX_SIZE) + AW'(nb_col[NW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      row_mem[wr_addr] <= {in_item_i.pixel_red, in_item_i.pixel_green,
                           in_item_i.pixel_blue};
    end
    rd_data_q <= row_mem[rd_addr];
  end

  // divider set-up values from the finished sums
  logic [2:0][36:0] mag;
  logic [20:0]      wmag;

  always_comb begin
    wmag = wsum_q[21] ? 21'(-wsum_q) : 21'(wsum_q);
    for (int k = 0; k < 3; k++) begin
      mag[k] = acc_q[k][37] ? 37'(-acc_q[k]) : 37'(acc_q[k]);
    end
  end

  // configuration, position and kernel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= 10'd512;
      in_row_q     <= '0;
      in_col_q     <= '0;
      in_slot_q    <= 3'd0;
      for (int k = 0; k < KTAPS; k++) begin
        coeff_q[k] <= '0;
      end
    end else if (cfg_fire) begin
      image_size_q <= cfg_data_i;
      in_row_q     <= '0;
      in_col_q     <= '0;
      in_slot_q    <= 3'd0;
    end else if (in_fire) begin
      if (in_item_i.kind == KIND_COEFF) begin
        if (32'(in_item_i.coeff_index) < KTAPS) begin
          coeff_q[in_item_i.coeff_index] <= in_item_i.coeff_value;
        end
      end else if (col_last) begin
        in_col_q <= '0;
        if (row_last) begin
          in_row_q  <= '0;
          in_slot_q <= 3'd0;
        end else begin
          in_row_q  <= px_row + NW'(1);
          in_slot_q <= mod5(4'(px_slot) + 4'd1);
        end
      end else begin
        in_row_q  <= px_row;
        in_slot_q <= px_slot;
        in_col_q  <= px_col + NW'(1);
      end
    end
  end

  // sequencer, accumulation and division
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      t_q         <= '0;
      dr_q        <= '0;
      dc_q        <= '0;
      drain_q     <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end

      // stage two: products of the registered store word
      v2_q <= v1_q;
      w2_q <= w1_q;
      if (v1_q) begin
        prod_q[0] <= signed'({1'b0, rd_data_q[47:32]}) * w1_q;
        prod_q[1] <= signed'({1'b0, rd_data_q[31:16]}) * w1_q;
        prod_q[2] <= signed'({1'b0, rd_data_q[15:0]}) * w1_q;
      end
      // stage three: running sums
      if (v2_q) begin
        for (int k = 0; k < 3; k++) begin
          acc_q[k] <= acc_q[k] + 38'(signed'(prod_q[k]));
        end
        wsum_q <= wsum_q + 22'(w2_q);
      end
      // taps outside the image are skipped
      v1_q <= (state_q == ST_TAPS) && nb_in;

      unique case (state_q)
        ST_IDLE: begin
          if (wr_en && has_rows && has_cols) begin
            r_q      <= (px_row >= NW'(2)) ? px_row - NW'(2) : '0;
            r_slot_q <= (px_row >= NW'(2)) ? mod5(4'(px_slot) + 4'd3) : 3'd0;
            r_hi_q   <= row_last ? n_eff - NW'(1) : px_row - NW'(2);
            c_q      <= (px_col >= NW'(2)) ? px_col - NW'(2) : '0;
            c_lo_q   <= (px_col >= NW'(2)) ? px_col - NW'(2) : '0;
            c_hi_q   <= col_last ? n_eff - NW'(1) : px_col - NW'(2);
            t_q      <= '0;
            dr_q     <= '0;
            dc_q     <= '0;
            acc_q    <= '0;
            wsum_q   <= '0;
            state_q  <= ST_TAPS;
          end
        end
        ST_TAPS: begin
          // one tap read issued per cycle
          w1_q <= coeff_q[t_q];
          if (dc_q == 3'(KSIDE - 1)) begin
            dc_q <= '0;
            dr_q <= dr_q + 3'd1;
          end else begin
            dc_q <= dc_q + 3'd1;
          end
          if (t_q == 5'(KTAPS - 1)) begin
            drain_q <= 1'b0;
            state_q <= ST_DRAIN;
          end else begin
            t_q <= t_q + 5'd1;
          end
        end
        ST_DRAIN: begin
          drain_q <= 1'b1;
          if (drain_q) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          zero_q    <= (wsum_q == '0);
          dsh_q     <= {1'b0, wmag, 15'd0};
          div_cnt_q <= '0;
          for (int k = 0; k < 3; k++) begin
            rem_q[k] <= mag[k];
            quo_q[k] <= '0;
            neg_q[k] <= (acc_q[k][37] != wsum_q[21]) && (acc_q[k] != '0);
            ovf_q[k] <= (mag[k] >= {wmag, 16'd0});
          end
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          // restoring division, one quotient bit per cycle
          for (int k = 0; k < 3; k++) begin
            if (rem_q[k] >= dsh_q) begin
              rem_q[k] <= rem_q[k] - dsh_q;
              quo_q[k] <= {quo_q[k][14:0], 1'b1};
            end else begin
              quo_q[k] <= {quo_q[k][14:0], 1'b0};
            end
          end
          dsh_q     <= dsh_q >> 1;
          div_cnt_q <= div_cnt_q + 4'd1;
          if (div_cnt_q == 4'd15) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_item_q.out_row      <= 9'(r_q);
            out_item_q.out_col      <= 9'(c_q);
            out_item_q.zero_weight  <= zero_q;
            out_item_q.last_of_run  <= (r_q == r_hi_q) && (c_q == c_hi_q);
            out_item_q.frame_end    <= (r_q == n_eff - NW'(1))
                                       && (c_q == n_eff - NW'(1));
            out_item_q.out_red      <= (zero_q || neg_q[0]) ? 16'd0 :
                                       ovf_q[0] ? 16'hFFFF : quo_q[0];
            out_item_q.out_green    <= (zero_q || neg_q[1]) ? 16'd0 :
                                       ovf_q[1] ? 16'hFFFF : quo_q[1];
            out_item_q.out_blue     <= (zero_q || neg_q[2]) ? 16'd0 :
                                       ovf_q[2] ? 16'hFFFF : quo_q[2];
            t_q    <= '0;
            dr_q   <= '0;
            dc_q   <= '0;
            acc_q  <= '0;
            wsum_q <= '0;
            if (c_q == c_hi_q) begin
              c_q <= c_lo_q;
              if (r_q == r_hi_q) begin
                state_q <= ST_IDLE;
              end else begin
                r_q      <= r_q + NW'(1);
                r_slot_q <= mod5(4'(r_slot_q) + 4'd1);
                state_q  <= ST_TAPS;
              end
            end else begin
              c_q     <= c_q + NW'(1);
              state_q <= ST_TAPS;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // the image's last pixel always closes its run
  a_frame_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.frame_end) |-> out_item_o.last_of_run)
    else $error("frame end without end of run");

  // zero weight sum forces all components to zero
  a_zero_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.zero_weight) |->
      (out_item_o.out_red == '0 && out_item_o.out_green == '0
       && out_item_o.out_blue == '0))
    else $error("zero weight with nonzero component");

  // a tap read is only in flight while taps are issued or draining
  a_pipe_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (state_q == ST_TAPS || state_q == ST_DRAIN))
    else $error("tap read outside accumulation window");

endmodule

// ===== test/normalized_5x5_convolution_tb.sv =====
// testbench for the normalized 5x5 convolution: directed and random frames against a model
`timescale 1ns / 1ps

module normalized_5x5_convolution_tb;
  import nc5_pkg::*;

  localparam int MAX_SIZE    = 512;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 600;  // room for nine results to drain, with margin
  localparam int HOLD_CYCLES = 400;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [9:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_item_o;

  normalized_5x5_convolution #(.MAX_SIZE(MAX_SIZE)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #2 clk_i = ~clk_i;

  // local copy of the filter state
  logic signed [15:0] kernel_w [KTAPS];
  logic [47:0]        line_mem [NSLOTS*MAX_SIZE];
  int                 pos_row, pos_col;
  logic [9:0]         size_reg;

  in_item_t  pending_items[$];
  out_item_t filtered_q[$];

  int  send_idle, recv_idle;
  bit  in_taken;
  bit  hold_req;
  int  hold_cnt;
  int  err_count, results_seen, pixels_sent, coeffs_sent, items_queued, frames_run;
  longint cycles;

  function automatic int eff_size();
    if (size_reg == 10'd0) return 1;
    if (size_reg > MAX_SIZE) return MAX_SIZE;
    return int'(size_reg);
  endfunction

  function automatic logic [15:0] sat16(longint q);
    if (q < 0) return 16'd0;
    if (q > 65535) return 16'hFFFF;
    return q[15:0];
  endfunction

  // weighted sum of the in-image neighbours, divided by the weights used
  function automatic out_item_t filter_pixel(int n, int r, int c);
    out_item_t res;
    longint acc_r, acc_g, acc_b, wsum, w;
    logic [47:0] px;
    acc_r = 0; acc_g = 0; acc_b = 0; wsum = 0;
    for (int dr = 0; dr < KSIDE; dr++) begin
      for (int dc = 0; dc < KSIDE; dc++) begin
        if (r+dr-2 >= 0 && r+dr-2 < n && c+dc-2 >= 0 && c+dc-2 < n) begin
          w  = longint'(kernel_w[dr*KSIDE+dc]);
          px = line_mem[((r+dr-2) % NSLOTS)*MAX_SIZE + c+dc-2];
          acc_r += longint'(px[47:32]) * w;
          acc_g += longint'(px[31:16]) * w;
          acc_b += longint'(px[15:0]) * w;
          wsum  += w;
        end
      end
    end
    res = '0;
    res.out_row = r[8:0];
    res.out_col = c[8:0];
    if (wsum == 0) begin
      res.zero_weight = 1'b1;
    end else begin
      res.out_red   = sat16(acc_r / wsum);
      res.out_green = sat16(acc_g / wsum);
      res.out_blue  = sat16(acc_b / wsum);
    end
    res.frame_end = (r == n-1 && c == n-1);
    return res;
  endfunction

  // update the model for one accepted transfer and queue what it should produce
  task automatic predict_item(in_item_t it);
    int n, rlo, rhi, clo, chi, cnt;
    out_item_t res;
    n = eff_size();
    if (it.kind == KIND_COEFF) begin
      if (it.coeff_index < KTAPS) kernel_w[it.coeff_index] = it.coeff_value;
      coeffs_sent++;
      return;
    end
    pixels_sent++;
    if (pos_row >= n || pos_col >= n) begin
      pos_row = 0; pos_col = 0;
    end
    line_mem[(pos_row % NSLOTS)*MAX_SIZE + pos_col] =
      {it.pixel_red, it.pixel_green, it.pixel_blue};
    rhi = (pos_row == n-1) ? n-1 : pos_row-2;
    rlo = (pos_row < 2) ? 0 : pos_row-2;
    chi = (pos_col == n-1) ? n-1 : pos_col-2;
    clo = (pos_col < 2) ? 0 : pos_col-2;
    cnt = 0;
    for (int r = rlo; r <= rhi; r++) begin
      for (int c = clo; c <= chi; c++) begin
        res = filter_pixel(n, r, c);
        filtered_q.push_back(res);
        cnt++;
      end
    end
    // last result of this pixel carries the run marker
    if (cnt > 0) filtered_q[filtered_q.size()-1].last_of_run = 1'b1;
    pos_col++;
    if (pos_col >= n) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= n) pos_row = 0;
    end
  endtask

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  // output check first, then the input transfer of the same edge feeds the model
  always @(posedge clk_i) begin
    out_item_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, filtered_q.size());
      $display("Verification failed");
      $finish;
    end else begin
      if (rst_ni && out_valid_o && out_ready_i) begin
        results_seen++;
        if (filtered_q.size() == 0) begin
          $error("result with nothing outstanding: row %0d col %0d",
                 out_item_o.out_row, out_item_o.out_col);
          err_count++;
        end else begin
          want = filtered_q.pop_front();
          check_field("out_row",     want.out_row,     out_item_o.out_row);
          check_field("out_col",     want.out_col,     out_item_o.out_col);
          check_field("out_red",     want.out_red,     out_item_o.out_red);
          check_field("out_green",   want.out_green,   out_item_o.out_green);
          check_field("out_blue",    want.out_blue,    out_item_o.out_blue);
          check_field("zero_weight", want.zero_weight, out_item_o.zero_weight);
          check_field("last_of_run", want.last_of_run, out_item_o.last_of_run);
          check_field("frame_end",   want.frame_end,   out_item_o.frame_end);
        end
      end
      in_taken = rst_ni && in_valid_i && in_ready_o;
      if (in_taken) predict_item(in_item_i);
    end
  end

  // input driver: a new item only once the previous transfer is done
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_item_i  <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output ready, with one long hold-off on request to back the block up
  always @(negedge clk_i) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      hold_cnt++;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic queue_coeff(int idx, int val);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.kind        = KIND_COEFF;
    it.coeff_index = idx[4:0];
    it.coeff_value = val[15:0];
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.kind        = KIND_PIXEL;
    it.pixel_red   = r;
    it.pixel_green = g;
    it.pixel_blue  = b;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // register writes only once the block has gone quiet
  task automatic write_size(logic [9:0] val);
    while (pending_items.size() != 0 || in_valid_i || filtered_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    size_reg = val;
    pos_row  = 0;
    pos_col  = 0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_frame(int n);
    int pick;
    frames_run++;
    write_size(n[9:0]);
    pick = $urandom_range(2);
    if (pick == 0) begin
      // full smoothing kernel, mostly positive weights
      for (int k = 0; k < KTAPS; k++)
        queue_coeff(k, ($urandom_range(9) == 0) ? -$urandom_range(4096)
                                                : $urandom_range(8192));
    end else begin
      repeat ($urandom_range(4)) queue_coeff($urandom_range(31), $urandom);
    end
    for (int p = 0; p < n*n; p++) begin
      if ($urandom_range(19) == 0) queue_coeff($urandom_range(31), $urandom);
      case ($urandom_range(7))
        0:       queue_pixel(16'h0000, 16'hFFFF, $urandom);
        1:       queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: queue_pixel($urandom, $urandom, $urandom);
      endcase
    end
  endtask

  initial begin
    foreach (kernel_w[k]) kernel_w[k] = '0;
    foreach (line_mem[k]) line_mem[k] = '0;
    size_reg = 10'd512;
    pos_row = 0; pos_col = 0;
    send_idle = 33; recv_idle = 51;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all-zero kernel after reset: every result flags a zero weight sum
    write_size(10'd3);
    for (int p = 0; p < 9; p++)
      queue_pixel((p % 2) ? 16'hFFFF : 16'h0000, 16'h8000, p[15:0]);
    // weight extremes, plus out-of-range indices that must be ignored
    write_size(10'd2);
    queue_coeff(12, 32767);
    queue_coeff(0, -32768);
    queue_coeff(31, 4096);
    queue_coeff(25, -1);
    for (int p = 0; p < 4; p++) queue_pixel(16'hFFFF, 16'h0001, 16'h7FFF);
    // size zero behaves as a single pixel image
    write_size(10'd0);
    queue_pixel(16'hFFFF, 16'h0000, 16'h1234);
    queue_pixel(16'h0000, 16'hFFFF, 16'hABCD);

    // random frames: three idling profiles, one long output stall early on
    hold_req = 1'b1;
    while (items_queued < 110) begin
      if (items_queued > 73) begin
        send_idle = 0; recv_idle = 0;
      end else if (items_queued > 45) begin
        send_idle = 51; recv_idle = 33;
      end
      random_frame(($urandom_range(3) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4));
    end

    // oversize value clamps to the largest image, then the largest size itself
    write_size(10'h3FF);
    repeat (6) queue_pixel($urandom, $urandom, $urandom);
    write_size(10'd512);
    repeat (3) queue_pixel($urandom, $urandom, $urandom);

    while (pending_items.size() != 0 || in_valid_i || filtered_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d frames: %0d pixel and %0d coefficient transfers, %0d results checked",
             frames_run, pixels_sent, coeffs_sent, results_seen);
    $display("image sizes 0 to 1023 written, weight and component extremes, long output stall");
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
